>>> rtl/core/nfdb_pkg.sv
`timescale 1ns / 1ps

package nfdb_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_PIXEL_COUNT = 65536;
	localparam int DEF_COORD_BITS  = 24;

	// Fixed field widths
	localparam int SCREEN_BITS    = 13;
	localparam int CAM_BITS       = 24;
	localparam int INTENSITY_BITS = 16;
	localparam int COLOUR_BITS    = 8;
	localparam int ATTR_BITS      = INTENSITY_BITS + 4 * COLOUR_BITS;

	// Configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_MODE      = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CAMERA_X       = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CAMERA_Y       = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CAMERA_Z       = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CAMERA_PRESENT = 3'd6;

	// View modes
	localparam logic MODE_3D = 1'b0;
	localparam logic MODE_2D = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_SQUARE,
		ST_SUM,
		ST_UPDATE
	} ctl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_en;
		logic load;
		logic index_en;
		logic square_en;
		logic sum_en;
		logic update_en;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_done;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/core/nfdb_if.sv
`timescale 1ns / 1ps

// Point channel
interface nfdb_point_if #(
	parameter int COORD_BITS = nfdb_pkg::DEF_COORD_BITS
);
	logic valid;
	logic ready;
	logic signed [nfdb_pkg::SCREEN_BITS-1:0] column;
	logic signed [nfdb_pkg::SCREEN_BITS-1:0] row;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic [nfdb_pkg::INTENSITY_BITS-1:0] intensity;
	logic [nfdb_pkg::COLOUR_BITS-1:0] red;
	logic [nfdb_pkg::COLOUR_BITS-1:0] green;
	logic [nfdb_pkg::COLOUR_BITS-1:0] blue;
	logic [nfdb_pkg::COLOUR_BITS-1:0] alpha;

	modport source (
		output valid, column, row, point_x, point_y, point_z,
			intensity, red, green, blue, alpha,
		input ready
	);
	modport sink (
		input valid, column, row, point_x, point_y, point_z,
			intensity, red, green, blue, alpha,
		output ready
	);
endinterface

// Result channel
interface nfdb_result_if #(
	parameter int COORD_BITS = nfdb_pkg::DEF_COORD_BITS
);
	logic valid;
	logic ready;
	logic accepted;
	logic first_at_pixel;
	logic near_changed;
	logic far_changed;
	logic signed [COORD_BITS-1:0] near_height;
	logic signed [COORD_BITS-1:0] far_height;

	modport source (
		output valid, accepted, first_at_pixel, near_changed, far_changed,
			near_height, far_height,
		input ready
	);
	modport sink (
		input valid, accepted, first_at_pixel, near_changed, far_changed,
			near_height, far_height,
		output ready
	);
endinterface

>>> rtl/core/nfdb_ctrl.sv
`timescale 1ns / 1ps

module nfdb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  nfdb_pkg::dp_status_t status,
	output nfdb_pkg::ctl_cmd_t   cmd
);

	nfdb_pkg::ctl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfdb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nfdb_pkg::ST_CLEAR: begin
				if (status.clear_done) state_d = nfdb_pkg::ST_IDLE;
			end
			nfdb_pkg::ST_IDLE: begin
				if (in_valid) state_d = nfdb_pkg::ST_INDEX;
			end
			nfdb_pkg::ST_INDEX:  state_d = nfdb_pkg::ST_SQUARE;
			nfdb_pkg::ST_SQUARE: state_d = nfdb_pkg::ST_SUM;
			nfdb_pkg::ST_SUM:    state_d = nfdb_pkg::ST_UPDATE;
			nfdb_pkg::ST_UPDATE: begin
				// hold until the output register can take the beat
				if (status.out_free) state_d = nfdb_pkg::ST_IDLE;
			end
			default: state_d = nfdb_pkg::ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			nfdb_pkg::ST_CLEAR:  cmd.clear_en = 1'b1;
			nfdb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			nfdb_pkg::ST_INDEX:  cmd.index_en = 1'b1;
			nfdb_pkg::ST_SQUARE: cmd.square_en = 1'b1;
			nfdb_pkg::ST_SUM:    cmd.sum_en = 1'b1;
			nfdb_pkg::ST_UPDATE: cmd.update_en = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/core/nfdb_datapath.sv
`timescale 1ns / 1ps

module nfdb_datapath #(
	parameter int PIXEL_COUNT = nfdb_pkg::DEF_PIXEL_COUNT,
	parameter int COORD_BITS  = nfdb_pkg::DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  nfdb_pkg::ctl_cmd_t                    cmd,
	output nfdb_pkg::dp_status_t                  status,
	// configuration
	input  logic                                  cfg_write,
	input  logic [nfdb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [nfdb_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// point payload
	input  logic signed [nfdb_pkg::SCREEN_BITS-1:0] column,
	input  logic signed [nfdb_pkg::SCREEN_BITS-1:0] row,
	input  logic signed [COORD_BITS-1:0]          point_x,
	input  logic signed [COORD_BITS-1:0]          point_y,
	input  logic signed [COORD_BITS-1:0]          point_z,
	input  logic [nfdb_pkg::INTENSITY_BITS-1:0]   intensity,
	input  logic [nfdb_pkg::COLOUR_BITS-1:0]      red,
	input  logic [nfdb_pkg::COLOUR_BITS-1:0]      green,
	input  logic [nfdb_pkg::COLOUR_BITS-1:0]      blue,
	input  logic [nfdb_pkg::COLOUR_BITS-1:0]      alpha,
	// result channel
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic                                  accepted,
	output logic                                  first_at_pixel,
	output logic                                  near_changed,
	output logic                                  far_changed,
	output logic signed [COORD_BITS-1:0]          near_height,
	output logic signed [COORD_BITS-1:0]          far_height
);

	localparam int SB     = nfdb_pkg::SCREEN_BITS;
	localparam int CB     = nfdb_pkg::CAM_BITS;
	localparam int ADDR_W = $clog2(PIXEL_COUNT);
	localparam int WMAX   = (COORD_BITS > CB) ? COORD_BITS : CB;
	localparam int DIFF_W = WMAX + 1;
	localparam int SQ_W   = 2 * WMAX;
	localparam int DIST_W = SQ_W + 2;
	localparam int IDX_W  = 2 * SB + 2;
	localparam int LIM_W  = 2 * SB;
	localparam int XY_W   = 2 * COORD_BITS;
	localparam int REC_W  = XY_W + nfdb_pkg::ATTR_BITS + COORD_BITS + DIST_W;

	// magnitude of a coordinate difference
	function automatic logic [WMAX-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
		logic signed [DIFF_W-1:0] n;
		n = -d;
		return d[DIFF_W-1] ? n[WMAX-1:0] : d[WMAX-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	logic                  mode_q;
	logic [SB-1:0]         width_q;
	logic [SB-1:0]         height_q;
	logic signed [CB-1:0]  cam_x_q;
	logic signed [CB-1:0]  cam_y_q;
	logic signed [CB-1:0]  cam_z_q;
	logic                  cam_present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= nfdb_pkg::MODE_3D;
			width_q       <= SB'(1);
			height_q      <= SB'(1);
			cam_x_q       <= '0;
			cam_y_q       <= '0;
			cam_z_q       <= '0;
			cam_present_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				nfdb_pkg::REG_VIEW_MODE:      mode_q        <= cfg_data[0];
				nfdb_pkg::REG_SCREEN_WIDTH:   width_q       <= cfg_data[SB-1:0];
				nfdb_pkg::REG_SCREEN_HEIGHT:  height_q      <= cfg_data[SB-1:0];
				nfdb_pkg::REG_CAMERA_X:       cam_x_q       <= cfg_data[CB-1:0];
				nfdb_pkg::REG_CAMERA_Y:       cam_y_q       <= cfg_data[CB-1:0];
				nfdb_pkg::REG_CAMERA_Z:       cam_z_q       <= cfg_data[CB-1:0];
				nfdb_pkg::REG_CAMERA_PRESENT: cam_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Point capture
	logic signed [SB-1:0]          col_q, row_q;
	logic signed [COORD_BITS-1:0]  px_q, py_q, pz_q;
	logic [nfdb_pkg::ATTR_BITS-1:0] attr_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q  <= column;
			row_q  <= row;
			px_q   <= point_x;
			py_q   <= point_y;
			pz_q   <= point_z;
			attr_q <= {intensity, red, green, blue, alpha};
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: pixel index, screen size, distance magnitudes
	logic signed [2*SB:0]     prod_c;
	logic signed [IDX_W-1:0]  idx_c;
	logic [LIM_W-1:0]         limit_c;
	logic signed [DIFF_W-1:0] dx_c, dy_c, dz_c;

	assign prod_c  = row_q * $signed({1'b0, width_q});
	assign idx_c   = $signed({prod_c[2*SB], prod_c})
		+ $signed({{(IDX_W-SB){col_q[SB-1]}}, col_q});
	assign limit_c = width_q * height_q;
	assign dx_c = $signed({{(DIFF_W-COORD_BITS){px_q[COORD_BITS-1]}}, px_q})
		- $signed({{(DIFF_W-CB){cam_x_q[CB-1]}}, cam_x_q});
	assign dy_c = $signed({{(DIFF_W-COORD_BITS){py_q[COORD_BITS-1]}}, py_q})
		- $signed({{(DIFF_W-CB){cam_y_q[CB-1]}}, cam_y_q});
	assign dz_c = $signed({{(DIFF_W-COORD_BITS){pz_q[COORD_BITS-1]}}, pz_q})
		- $signed({{(DIFF_W-CB){cam_z_q[CB-1]}}, cam_z_q});

	logic signed [IDX_W-1:0] idx_s1;
	logic [LIM_W-1:0]        limit_s1;
	logic [WMAX-1:0]         mag_s1 [3];

	always_ff @(posedge clk) begin
		if (cmd.index_en) begin
			idx_s1    <= idx_c;
			limit_s1  <= limit_c;
			mag_s1[0] <= mag_of(dx_c);
			mag_s1[1] <= mag_of(dy_c);
			mag_s1[2] <= mag_of(dz_c);
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: squares, reject test, memory read
	logic [ADDR_W-1:0] pix_addr;
	logic [SQ_W-1:0]   sq_s2 [3];
	logic              rej_s2;

	assign pix_addr = idx_s1[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.square_en) begin
			sq_s2[0] <= mag_s1[0] * mag_s1[0];
			sq_s2[1] <= mag_s1[1] * mag_s1[1];
			sq_s2[2] <= mag_s1[2] * mag_s1[2];
			rej_s2   <= idx_s1[IDX_W-1]
				|| (idx_s1 >= $signed({2'b00, limit_s1}))
				|| (idx_s1 >= $signed(IDX_W'(PIXEL_COUNT)))
				|| (mode_q == nfdb_pkg::MODE_3D && !cam_present_q);
		end
	end

	// Stage 3: squared distance
	logic [DIST_W-1:0] dist_s3;

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			dist_s3 <= DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);
		end
	end

	// ---------------------------------------------------------------
	// Pixel stores: valid bits, near and far records
	logic             vld_mem  [PIXEL_COUNT];
	logic [REC_W-1:0] near_mem [PIXEL_COUNT];
	logic [REC_W-1:0] far_mem  [PIXEL_COUNT];
	logic             vld_rd_s2;
	logic [REC_W-1:0] near_rd_s2, far_rd_s2;

	logic              vld_we, vld_wdata, near_we, far_we;
	logic [ADDR_W-1:0] vld_waddr;
	logic [REC_W-1:0]  rec_new;

	always_ff @(posedge clk) begin
		if (vld_we) vld_mem[vld_waddr] <= vld_wdata;
		if (cmd.square_en) vld_rd_s2 <= vld_mem[pix_addr];
	end

	always_ff @(posedge clk) begin
		if (near_we) near_mem[pix_addr] <= rec_new;
		if (cmd.square_en) near_rd_s2 <= near_mem[pix_addr];
	end

	always_ff @(posedge clk) begin
		if (far_we) far_mem[pix_addr] <= rec_new;
		if (cmd.square_en) far_rd_s2 <= far_mem[pix_addr];
	end

	// Clearing pass over the valid bits after reset
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_en) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign status.clear_done = (clr_addr_q == ADDR_W'(PIXEL_COUNT - 1));

	// ---------------------------------------------------------------
	// Update: compare against stored records
	logic signed [COORD_BITS-1:0] near_h, far_h;
	logic [DIST_W-1:0]            near_d, far_d;
	logic                         first_c, near_upd, far_upd, commit;

	assign near_h = near_rd_s2[DIST_W +: COORD_BITS];
	assign far_h  = far_rd_s2[DIST_W +: COORD_BITS];
	assign near_d = near_rd_s2[DIST_W-1:0];
	assign far_d  = far_rd_s2[DIST_W-1:0];
	assign first_c = !vld_rd_s2;

	always_comb begin
		near_upd = 1'b0;
		far_upd  = 1'b0;
		if (!rej_s2) begin
			if (first_c) begin
				near_upd = 1'b1;
				far_upd  = 1'b1;
			end else if (mode_q == nfdb_pkg::MODE_3D) begin
				near_upd = dist_s3 < near_d;
				far_upd  = dist_s3 > far_d;
			end else begin
				near_upd = pz_q > near_h;
				far_upd  = pz_q < far_h;
			end
		end
	end

	assign commit  = cmd.update_en && !rej_s2;
	assign rec_new = {px_q, py_q, attr_q, pz_q, dist_s3};
	assign near_we = commit && near_upd;
	assign far_we  = commit && far_upd;

	// valid-bit write port shared by clearing pass and update
	assign vld_we    = cmd.clear_en || commit;
	assign vld_waddr = cmd.clear_en ? clr_addr_q : pix_addr;
	assign vld_wdata = !cmd.clear_en;

	// ---------------------------------------------------------------
	// Output register
	logic                         res_valid_q;
	logic                         acc_q, first_q, near_chg_q, far_chg_q;
	logic signed [COORD_BITS-1:0] near_h_q, far_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.update_en) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update_en) begin
			acc_q      <= !rej_s2;
			first_q    <= !rej_s2 && first_c;
			near_chg_q <= near_upd;
			far_chg_q  <= far_upd;
			near_h_q   <= rej_s2 ? '0 : (near_upd ? pz_q : near_h);
			far_h_q    <= rej_s2 ? '0 : (far_upd ? pz_q : far_h);
		end
	end

	assign status.out_free = !res_valid_q || out_ready;

	assign out_valid      = res_valid_q;
	assign accepted       = acc_q;
	assign first_at_pixel = first_q;
	assign near_changed   = near_chg_q;
	assign far_changed    = far_chg_q;
	assign near_height    = near_h_q;
	assign far_height     = far_h_q;

endmodule

>>> rtl/core/near_far_depth_buffer_unit.sv
// Near/far depth buffer. Each point beat carries a screen column and row, a
// position, an intensity and a colour; the block keeps, per pixel
// (index = row * screen_width + column), the nearest and farthest point seen,
// ordered by squared camera distance in 3D mode or by z in 2D mode, and
// answers every point with exactly one result beat. Off-screen points, and
// 3D-mode points with no camera, come back with every field zero. After a point
// is accepted it goes through the index, square and sum states, then compare
// and write-back into the result register, which waits while the result side
// stalls; the block takes no new point until that write-back is done and it is
// back in idle. After reset the pixel valid bits are swept clear, one pixel per
// cycle, and the block takes no point until the sweep is done; configuration
// writes are taken at any time, but should only be issued while no point is in
// flight.
`timescale 1ns / 1ps

module near_far_depth_buffer_unit #(
	parameter int PIXEL_COUNT = nfdb_pkg::DEF_PIXEL_COUNT,
	parameter int COORD_BITS  = nfdb_pkg::DEF_COORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	nfdb_point_if.sink                          points,
	nfdb_result_if.source                       results,
	input  logic                                cfg_write,
	input  logic [nfdb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [nfdb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	nfdb_pkg::ctl_cmd_t   cmd;
	nfdb_pkg::dp_status_t status;

	// Sequencer
	nfdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_ready (points.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and pixel stores
	nfdb_datapath #(
		.PIXEL_COUNT (PIXEL_COUNT),
		.COORD_BITS  (COORD_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.column         (points.column),
		.row            (points.row),
		.point_x        (points.point_x),
		.point_y        (points.point_y),
		.point_z        (points.point_z),
		.intensity      (points.intensity),
		.red            (points.red),
		.green          (points.green),
		.blue           (points.blue),
		.alpha          (points.alpha),
		.out_ready      (results.ready),
		.out_valid      (results.valid),
		.accepted       (results.accepted),
		.first_at_pixel (results.first_at_pixel),
		.near_changed   (results.near_changed),
		.far_changed    (results.far_changed),
		.near_height    (results.near_height),
		.far_height     (results.far_height)
	);

endmodule

>>> rtl/core/nfdb_checker.sv
`timescale 1ns / 1ps

module nfdb_checker #(
	parameter int COORD_BITS = nfdb_pkg::DEF_COORD_BITS
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         accepted,
	input logic                         first_at_pixel,
	input logic                         near_changed,
	input logic                         far_changed,
	input logic signed [COORD_BITS-1:0] near_height,
	input logic signed [COORD_BITS-1:0] far_height
);

	// stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted)
			&& $stable(near_height) && $stable(far_height))
		else $error("result beat changed while stalled");

	// rejected point reports nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> !first_at_pixel && !near_changed
			&& !far_changed && near_height == '0 && far_height == '0)
		else $error("rejected point carries non-zero fields");

	// first point of a pixel sets both records
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_at_pixel |-> accepted && near_changed && far_changed)
		else $error("first point did not set both records");

	// both records then hold the same height
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_at_pixel |-> near_height == far_height)
		else $error("first point left differing heights");

endmodule

bind near_far_depth_buffer_unit nfdb_checker #(
	.COORD_BITS (COORD_BITS)
) u_nfdb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.accepted       (results.accepted),
	.first_at_pixel (results.first_at_pixel),
	.near_changed   (results.near_changed),
	.far_changed    (results.far_changed),
	.near_height    (results.near_height),
	.far_height     (results.far_height)
);

>>> dv/depth_record_checker.sv
`timescale 1ns / 1ps

module depth_record_checker
	import nfdb_pkg::*;
#(
	parameter int PIXEL_COUNT = DEF_PIXEL_COUNT,
	parameter int COORD_BITS  = DEF_COORD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	nfdb_point_if                     pts,
	nfdb_result_if                    res,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        fail_count,
	output int                        pending
);

	typedef struct packed {
		logic                         accepted;
		logic                         first_at_pixel;
		logic                         near_changed;
		logic                         far_changed;
		logic signed [COORD_BITS-1:0] near_height;
		logic signed [COORD_BITS-1:0] far_height;
	} depth_result_t;

	// Register copies
	logic                       view_mode;
	logic [SCREEN_BITS-1:0]     width_reg;
	logic [SCREEN_BITS-1:0]     height_reg;
	logic signed [CAM_BITS-1:0] cam_x;
	logic signed [CAM_BITS-1:0] cam_y;
	logic signed [CAM_BITS-1:0] cam_z;
	logic                       cam_present;

	// Per-pixel records, only the parts that reach the result beat
	bit                           pixel_filled [PIXEL_COUNT];
	logic signed [COORD_BITS-1:0] near_z       [PIXEL_COUNT];
	logic signed [COORD_BITS-1:0] far_z        [PIXEL_COUNT];
	longint unsigned              near_dsq     [PIXEL_COUNT];
	longint unsigned              far_dsq      [PIXEL_COUNT];

	depth_result_t awaited_results [$];
	int            result_beats;

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
				result_beats, field, got, want));
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		case (idx)
			REG_VIEW_MODE:      view_mode   = value[0];
			REG_SCREEN_WIDTH:   width_reg   = value[SCREEN_BITS-1:0];
			REG_SCREEN_HEIGHT:  height_reg  = value[SCREEN_BITS-1:0];
			REG_CAMERA_X:       cam_x       = value[CAM_BITS-1:0];
			REG_CAMERA_Y:       cam_y       = value[CAM_BITS-1:0];
			REG_CAMERA_Z:       cam_z       = value[CAM_BITS-1:0];
			REG_CAMERA_PRESENT: cam_present = value[0];
			default: ;
		endcase
	endtask

	// Update the pixel's near/far records and return the beat they produce
	function automatic depth_result_t update_depth_records(
		input logic signed [SCREEN_BITS-1:0] col,
		input logic signed [SCREEN_BITS-1:0] row,
		input logic signed [COORD_BITS-1:0]  px,
		input logic signed [COORD_BITS-1:0]  py,
		input logic signed [COORD_BITS-1:0]  pz
	);
		depth_result_t   r;
		longint          pix;
		longint          area;
		longint          dx;
		longint          dy;
		longint          dz;
		longint unsigned dsq;
		bit              upd_near;
		bit              upd_far;
		int              p;
		r    = '0;
		pix  = longint'(row) * longint'(width_reg) + longint'(col);
		area = longint'(width_reg) * longint'(height_reg);
		if (pix < 0 || pix >= area || pix >= longint'(PIXEL_COUNT))
			return r;
		if (view_mode == MODE_3D && !cam_present)
			return r;
		p   = int'(pix);
		dx  = longint'(px) - longint'(cam_x);
		dy  = longint'(py) - longint'(cam_y);
		dz  = longint'(pz) - longint'(cam_z);
		dsq = dx * dx + dy * dy + dz * dz;
		upd_near = 1'b0;
		upd_far  = 1'b0;
		if (!pixel_filled[p]) begin
			// empty pixel: both records taken, distance stored in any mode
			r.first_at_pixel = 1'b1;
			upd_near         = 1'b1;
			upd_far          = 1'b1;
			pixel_filled[p]  = 1'b1;
		end else if (view_mode == MODE_3D) begin
			upd_far  = dsq > far_dsq[p];
			upd_near = dsq < near_dsq[p];
		end else begin
			upd_far  = pz < far_z[p];
			upd_near = pz > near_z[p];
		end
		if (upd_near) begin
			near_z[p]   = pz;
			near_dsq[p] = dsq;
		end
		if (upd_far) begin
			far_z[p]   = pz;
			far_dsq[p] = dsq;
		end
		r.accepted     = 1'b1;
		r.near_changed = upd_near;
		r.far_changed  = upd_far;
		r.near_height  = near_z[p];
		r.far_height   = far_z[p];
		return r;
	endfunction

	// Watch config, results and points on every rising edge
	always @(posedge clk or negedge arst_n) begin
		depth_result_t want;
		if (!arst_n) begin
			view_mode    = MODE_3D;
			width_reg    = SCREEN_BITS'(1);
			height_reg   = SCREEN_BITS'(1);
			cam_x        = '0;
			cam_y        = '0;
			cam_z        = '0;
			cam_present  = 1'b0;
			fail_count   = 0;
			result_beats = 0;
			foreach (pixel_filled[i])
				pixel_filled[i] = 1'b0;
			awaited_results.delete();
		end else begin
			if (cfg_write === 1'b1)
				write_register(cfg_index, cfg_data);
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no point outstanding",
						result_beats));
				end else begin
					want = awaited_results.pop_front();
					check_field("accepted", res.accepted, want.accepted);
					check_field("first_at_pixel", res.first_at_pixel, want.first_at_pixel);
					check_field("near_changed", res.near_changed, want.near_changed);
					check_field("far_changed", res.far_changed, want.far_changed);
					check_field("near_height", res.near_height, want.near_height);
					check_field("far_height", res.far_height, want.far_height);
				end
				result_beats++;
			end
			if (pts.valid === 1'b1 && pts.ready === 1'b1)
				awaited_results.push_back(update_depth_records(pts.column, pts.row,
					pts.point_x, pts.point_y, pts.point_z));
		end
		pending = awaited_results.size();
	end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import nfdb_pkg::*;

	localparam int PIXELS        = DEF_PIXEL_COUNT;
	localparam int CB            = DEF_COORD_BITS;
	localparam int COORD_MAX     = (1 << (CB - 1)) - 1;
	localparam int COORD_MIN     = -(1 << (CB - 1));
	localparam int CYCLE_LIMIT   = 600000;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS   = 121;
	localparam int POOL_SIZE     = 6;

	typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} attr_fill_t;

	typedef struct {
		logic signed [SCREEN_BITS-1:0]  column;
		logic signed [SCREEN_BITS-1:0]  row;
		logic signed [CB-1:0]           x;
		logic signed [CB-1:0]           y;
		logic signed [CB-1:0]           z;
		logic [INTENSITY_BITS-1:0]      intensity;
		logic [COLOUR_BITS-1:0]         red;
		logic [COLOUR_BITS-1:0]         green;
		logic [COLOUR_BITS-1:0]         blue;
		logic [COLOUR_BITS-1:0]         alpha;
	} point_beat_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_write;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int                        fail_count;
	int                        pending;

	int cycle_count;
	int points_offered;
	int setups_written;
	int src_gap_max;
	int sink_gap_max;
	bit hold_off_request;

	nfdb_point_if  #(.COORD_BITS(CB)) pts ();
	nfdb_result_if #(.COORD_BITS(CB)) res ();

	near_far_depth_buffer_unit #(
		.PIXEL_COUNT(PIXELS),
		.COORD_BITS (CB)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.points   (pts),
		.results  (res),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	depth_record_checker #(
		.PIXEL_COUNT(PIXELS),
		.COORD_BITS (CB)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pts       (pts),
		.res       (res),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Run stopped after %0d cycles with %0d results outstanding",
					cycle_count, pending);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Result side: random stalls per beat, plus one long hold-off on request
	initial begin
		int stall;
		bit hold_done;
		res.ready = 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_request && !hold_done) begin
				hold_done = 1'b1;
				res.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			stall = $urandom_range(0, sink_gap_max);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!(res.valid === 1'b1 && res.ready === 1'b1))
				@(posedge clk);
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(value);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain_results();
		pts.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_setup(input logic mode, input int w, input int h, input int cx,
			input int cy, input int cz, input bit present);
		drain_results();
		write_reg(REG_VIEW_MODE, mode);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_CAMERA_X, cx);
		write_reg(REG_CAMERA_Y, cy);
		write_reg(REG_CAMERA_Z, cz);
		write_reg(REG_CAMERA_PRESENT, present);
		setups_written++;
	endtask

	// One point beat, after a random gap; returns at the falling edge after acceptance
	task automatic offer_point(input point_beat_t p);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			pts.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pts.column    <= p.column;
		pts.row       <= p.row;
		pts.point_x   <= p.x;
		pts.point_y   <= p.y;
		pts.point_z   <= p.z;
		pts.intensity <= p.intensity;
		pts.red       <= p.red;
		pts.green     <= p.green;
		pts.blue      <= p.blue;
		pts.alpha     <= p.alpha;
		pts.valid     <= 1'b1;
		@(posedge clk);
		while (pts.ready !== 1'b1)
			@(posedge clk);
		points_offered++;
		@(negedge clk);
	endtask

	task automatic aim(input int col, input int row, input int x, input int y, input int z,
			input attr_fill_t fill = FILL_RANDOM);
		point_beat_t p;
		p.column    = SCREEN_BITS'(col);
		p.row       = SCREEN_BITS'(row);
		p.x         = CB'(x);
		p.y         = CB'(y);
		p.z         = CB'(z);
		p.intensity = INTENSITY_BITS'($urandom);
		p.red       = COLOUR_BITS'($urandom);
		p.green     = COLOUR_BITS'($urandom);
		p.blue      = COLOUR_BITS'($urandom);
		p.alpha     = COLOUR_BITS'($urandom);
		if (fill != FILL_RANDOM) begin
			p.intensity = (fill == FILL_ONES) ? '1 : '0;
			p.red       = (fill == FILL_ONES) ? '1 : '0;
			p.green     = (fill == FILL_ONES) ? '1 : '0;
			p.blue      = (fill == FILL_ONES) ? '1 : '0;
			p.alpha     = (fill == FILL_ONES) ? '1 : '0;
		end
		offer_point(p);
	endtask

	// Coordinate near a centre (to force ties), at an extreme, or anywhere
	function automatic int pick_coord(input int centre, input bit tight);
		int v;
		if (tight)
			v = centre + int'($urandom_range(0, 12)) - 6;
		else if ($urandom_range(0, 7) == 0)
			v = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		else
			v = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
		if (v > COORD_MAX)
			v = COORD_MAX;
		if (v < COORD_MIN)
			v = COORD_MIN;
		return v;
	endfunction

	task automatic run_directed();
		// reset setup is 3D with no camera: rejected
		aim(0, 0, 1, 2, 3);

		// 2D height ordering on a single pixel screen, no camera needed
		apply_setup(MODE_2D, 1, 1, 0, 0, 0, 1'b0);
		aim(0, 0, 5, -5, 100, FILL_ONES);
		aim(0, 0, 0, 0, COORD_MAX);
		aim(0, 0, 0, 0, COORD_MIN, FILL_ZEROS);
		aim(0, 0, 0, 0, 0);
		aim(0, 0, 0, 0, COORD_MAX);
		aim(-1, 0, 0, 0, 0);
		aim(1, 0, 0, 0, 0);
		aim(0, 1, 0, 0, 0);
		aim(-4096, -4096, 0, 0, 0);
		aim(4095, 4095, 0, 0, 0);

		// switch to 3D over a filled pixel; pixel store bound at the largest screen
		apply_setup(MODE_3D, 4096, 4096, 0, 0, 0, 1'b1);
		aim(0, 0, 0, 0, 0);
		aim(0, 0, COORD_MAX, COORD_MAX, COORD_MAX);
		aim(4095, 15, COORD_MIN, COORD_MIN, COORD_MIN);
		aim(0, 16, 0, 0, 0);
		aim(-1, 16, 0, 0, 0);

		// zero width, then zero height
		apply_setup(MODE_3D, 0, 7, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
		aim(0, 0, 0, 0, 0);
		apply_setup(MODE_3D, 3, 0, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
		aim(0, 0, 0, 0, 0);

		// camera at the extremes, farthest possible point
		apply_setup(MODE_3D, 3, 2, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
		aim(0, 0, COORD_MIN, COORD_MAX, COORD_MIN);
		aim(2, 1, 7, -7, 7);

		// camera dropped in 3D
		apply_setup(MODE_3D, 2, 2, 0, 0, 0, 1'b0);
		aim(1, 1, 0, 0, 0);
	endtask

	task automatic run_random_phase(input bit long_hold, input bit mid_pause);
		int          w;
		int          h;
		int          reach;
		int          sel;
		int          idx;
		int          col;
		int          row;
		int          cam [3];
		int          pool [POOL_SIZE];
		bit          tight;
		point_beat_t p;

		// screen: mostly small so pixels are hit repeatedly
		case ($urandom_range(0, 9))
			0: begin w = 4096; h = 4096; end
			1: begin w = 1; h = $urandom_range(1, 4096); end
			2: begin w = $urandom_range(0, 1) ? 0 : 5; h = (w == 0) ? 6 : 0; end
			3: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 16); end
			default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
		endcase
		sel = $urandom_range(0, 3);
		foreach (cam[i]) begin
			case (sel)
				0: cam[i] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
				1: cam[i] = int'($urandom_range(0, 200)) - 100;
				default: cam[i] = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
			endcase
		end
		apply_setup(1'($urandom_range(0, 1)), w, h, cam[0], cam[1], cam[2],
			$urandom_range(0, 9) != 0);

		tight = $urandom_range(0, 1);
		if ($urandom_range(0, 3) == 0) begin
			src_gap_max  = 0;
			sink_gap_max = 0;
		end else begin
			src_gap_max  = 7;
			sink_gap_max = 7;
		end

		// pixels reachable with an in-range row
		reach = w * h;
		if (reach > PIXELS)
			reach = PIXELS;
		if (reach > 4096 * w)
			reach = 4096 * w;
		foreach (pool[i])
			pool[i] = (reach > 0) ? $urandom_range(0, reach - 1) : 0;

		if (long_hold)
			hold_off_request = 1'b1;

		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (mid_pause && n == PHASE_ITEMS / 2)
				drain_results();
			sel = $urandom_range(0, 19);
			if (reach == 0 || sel < 3) begin
				// noise: any column and row
				col = int'($urandom_range(0, 8191)) - 4096;
				row = int'($urandom_range(0, 8191)) - 4096;
			end else begin
				idx = (sel < 15) ? pool[$urandom_range(0, POOL_SIZE - 1)]
					: $urandom_range(0, reach - 1);
				row = idx / w;
				col = idx % w;
				// same pixel through a column outside the row
				if (sel == 3 && row < 4095 && col - w >= -4096) begin
					row++;
					col -= w;
				end else if (sel == 4 && row > 0 && col + w <= 4095) begin
					row--;
					col += w;
				end
			end
			p.column    = SCREEN_BITS'(col);
			p.row       = SCREEN_BITS'(row);
			p.x         = CB'(pick_coord(cam[0], tight));
			p.y         = CB'(pick_coord(cam[1], tight));
			p.z         = CB'(pick_coord(cam[2], tight));
			p.intensity = INTENSITY_BITS'($urandom);
			p.red       = COLOUR_BITS'($urandom);
			p.green     = COLOUR_BITS'($urandom);
			p.blue      = COLOUR_BITS'($urandom);
			p.alpha     = COLOUR_BITS'($urandom);
			offer_point(p);
		end
	endtask

	// Stimulus and verdict
	initial begin
		int directed_items;
		arst_n           = 1'b0;
		cfg_write        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		pts.valid        = 1'b0;
		pts.column       = '0;
		pts.row          = '0;
		pts.point_x      = '0;
		pts.point_y      = '0;
		pts.point_z      = '0;
		pts.intensity    = '0;
		pts.red          = '0;
		pts.green        = '0;
		pts.blue         = '0;
		pts.alpha        = '0;
		points_offered   = 0;
		setups_written   = 0;
		src_gap_max      = 7;
		sink_gap_max     = 7;
		hold_off_request = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		directed_items = points_offered;
		for (int ph = 0; ph < RANDOM_PHASES; ph++)
			run_random_phase(ph == 1, ph == 2);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d point beats (%0d directed) over %0d register setups, %0d cycles",
			points_offered, directed_items, setups_written, cycle_count);
		$display("Included a %0d-cycle result hold-off and a mid-stream drain; %0d mismatches",
			LONG_HOLD, fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
